[rtl/core/gcdlcm_pkg.sv]
// Package for the GCD/LCM block: widths, datapath operation codes and
// the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package gcdlcm_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RESULT_WIDTH  = 48;
  // GCD and division work on values up to a two-operand LCM.
  localparam int GCD_WIDTH     = 2 * OPERAND_WIDTH;
  localparam int ACC_WIDTH     = (3 * OPERAND_WIDTH > RESULT_WIDTH) ?
                                 3 * OPERAND_WIDTH : RESULT_WIDTH;
  localparam int SHIFT_WIDTH   = $clog2(GCD_WIDTH + 1);
  localparam int CNT_WIDTH     = $clog2(GCD_WIDTH);

  typedef logic [3:0] dp_op_t;

  localparam dp_op_t OP_NONE       = 4'd0;
  localparam dp_op_t OP_LOAD       = 4'd1;
  localparam dp_op_t OP_GCD_START  = 4'd2;
  localparam dp_op_t OP_SHIFT_BOTH = 4'd3;
  localparam dp_op_t OP_SHIFT_X    = 4'd4;
  localparam dp_op_t OP_GCD_STEP   = 4'd5;
  localparam dp_op_t OP_GCD_FINISH = 4'd6;
  localparam dp_op_t OP_MOVE_G     = 4'd7;
  localparam dp_op_t OP_DIV_START  = 4'd8;
  localparam dp_op_t OP_DIV_STEP   = 4'd9;
  localparam dp_op_t OP_MUL_START  = 4'd10;
  localparam dp_op_t OP_MUL_STEP   = 4'd11;
  localparam dp_op_t OP_FINAL      = 4'd12;

  typedef struct packed {
    dp_op_t op;
    logic   sel_c;
  } dp_cmd_t;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic both_even;
    logic x_even;
    logic is_lcm;
    logic three;
    logic lcm_zero;
    logic div_last;
    logic mul_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/gcdlcm_in_if.sv]
// Request channel of the GCD/LCM block: valid/ready and the input item.
// Depends on gcdlcm_pkg.
`default_nettype none

interface gcdlcm_in_if;
  import gcdlcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic                     three_operands;
  logic [OPERAND_WIDTH-1:0] operand_a;
  logic [OPERAND_WIDTH-1:0] operand_b;
  logic [OPERAND_WIDTH-1:0] operand_c;

  modport source (output valid, cmd, three_operands, operand_a, operand_b, operand_c,
                  input ready);
  modport sink (input valid, cmd, three_operands, operand_a, operand_b, operand_c,
                output ready);
endinterface

`default_nettype wire

[rtl/core/gcdlcm_out_if.sv]
// Result channel of the GCD/LCM block: valid/ready and the result item.
// Depends on gcdlcm_pkg.
`default_nettype none

interface gcdlcm_out_if;
  import gcdlcm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [RESULT_WIDTH-1:0] result_value;
  logic                    error_flag;

  modport source (output valid, result_value, error_flag, input ready);
  modport sink (input valid, result_value, error_flag, output ready);
endinterface

`default_nettype wire

[rtl/core/gcdlcm_dp.sv]
// Datapath of the GCD/LCM block: binary GCD registers, restoring divider,
// shift-add multiplier and the result register. Depends on gcdlcm_pkg.
`default_nettype none

module gcdlcm_dp (
  input  logic                                 clk,
  input  logic                                 cmd_in,
  input  logic                                 three_in,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0] a_in,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0] b_in,
  input  logic [gcdlcm_pkg::OPERAND_WIDTH-1:0] c_in,
  input  gcdlcm_pkg::dp_cmd_t                  dcmd,
  output gcdlcm_pkg::dp_sts_t                  sts,
  output logic [gcdlcm_pkg::RESULT_WIDTH-1:0]  result_value,
  output logic                                 error_flag
);
  import gcdlcm_pkg::*;

  logic                     is_lcm;
  logic                     three;
  logic                     lcm_zero;
  logic [OPERAND_WIDTH-1:0] opb;
  logic [OPERAND_WIDTH-1:0] opc;
  logic [OPERAND_WIDTH-1:0] opnd;
  logic [ACC_WIDTH-1:0]     cur;
  logic [GCD_WIDTH-1:0]     x;
  logic [GCD_WIDTH-1:0]     y;
  logic [GCD_WIDTH-1:0]     g;
  logic [SHIFT_WIDTH-1:0]   shift;
  logic [GCD_WIDTH-1:0]     rem;
  logic [GCD_WIDTH-1:0]     divq;
  logic [GCD_WIDTH:0]       rem_s;
  logic                     rem_ge;
  logic [ACC_WIDTH-1:0]     madd;
  logic [OPERAND_WIDTH-1:0] mreg;
  logic [CNT_WIDTH-1:0]     cnt;
  logic                     err;

  assign opnd   = dcmd.sel_c ? opc : opb;
  assign rem_s  = {rem, divq[GCD_WIDTH-1]};
  assign rem_ge = rem_s >= {1'b0, g};
  assign err    = is_lcm ? lcm_zero : (cur == '0);

  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_LOAD: begin
        is_lcm   <= cmd_in;
        three    <= three_in;
        opb      <= b_in;
        opc      <= c_in;
        lcm_zero <= (a_in == '0) || (b_in == '0) || (three_in && (c_in == '0));
        cur      <= ACC_WIDTH'(a_in);
      end
      OP_GCD_START: begin
        x     <= cur[GCD_WIDTH-1:0];
        y     <= GCD_WIDTH'(opnd);
        shift <= '0;
      end
      OP_SHIFT_BOTH: begin
        x     <= x >> 1;
        y     <= y >> 1;
        shift <= shift + 1'b1;
      end
      OP_SHIFT_X: begin
        x <= x >> 1;
      end
      OP_GCD_STEP: begin
        // x is odd here; an odd y is reduced by the smaller of the two.
        if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= y;
          y <= x - y;
        end else begin
          y <= y - x;
        end
      end
      OP_GCD_FINISH: begin
        g <= (x == '0) ? y : (x << shift);
      end
      OP_MOVE_G: begin
        cur <= ACC_WIDTH'(g);
      end
      OP_DIV_START: begin
        divq <= cur[GCD_WIDTH-1:0];
        rem  <= '0;
        cnt  <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_ge) begin
          rem <= GCD_WIDTH'(rem_s - {1'b0, g});
        end else begin
          rem <= rem_s[GCD_WIDTH-1:0];
        end
        divq <= {divq[GCD_WIDTH-2:0], rem_ge};
        cnt  <= cnt + 1'b1;
      end
      OP_MUL_START: begin
        cur  <= '0;
        madd <= ACC_WIDTH'(divq);
        mreg <= opnd;
        cnt  <= '0;
      end
      OP_MUL_STEP: begin
        if (mreg[0]) begin
          cur <= cur + madd;
        end
        madd <= madd << 1;
        mreg <= mreg >> 1;
        cnt  <= cnt + 1'b1;
      end
      OP_FINAL: begin
        result_value <= err ? '0 : cur[RESULT_WIDTH-1:0];
        error_flag   <= err;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.x_zero    = (x == '0);
    sts.y_zero    = (y == '0);
    sts.both_even = !x[0] && !y[0];
    sts.x_even    = !x[0];
    sts.is_lcm    = is_lcm;
    sts.three     = three;
    sts.lcm_zero  = lcm_zero;
    sts.div_last  = (cnt == CNT_WIDTH'(GCD_WIDTH - 1));
    sts.mul_last  = (cnt == CNT_WIDTH'(OPERAND_WIDTH - 1));
  end

endmodule

`default_nettype wire

[rtl/core/gcdlcm_ctrl.sv]
// Controller of the GCD/LCM block: sequences GCD, division and
// multiplication passes and runs both handshakes. Depends on gcdlcm_pkg.
`default_nettype none

module gcdlcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  gcdlcm_pkg::dp_sts_t sts,
  output gcdlcm_pkg::dp_cmd_t dcmd
);
  import gcdlcm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_GINIT = 4'd2;
  localparam logic [3:0] S_GODD  = 4'd3;
  localparam logic [3:0] S_GLOOP = 4'd4;
  localparam logic [3:0] S_AFTER = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MULS  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_FINAL = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       sel_c;
  logic       sel_c_next;
  logic       rsp_valid_next;
  logic       fin_fire;

  assign req_ready = (state == S_IDLE);
  assign fin_fire  = (state == S_FINAL) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    sel_c_next = sel_c;
    dcmd.op    = OP_NONE;
    dcmd.sel_c = sel_c;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          dcmd.op    = OP_LOAD;
          sel_c_next = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_lcm && sts.lcm_zero) begin
          state_next = S_FINAL;
        end else begin
          dcmd.op    = OP_GCD_START;
          state_next = S_GINIT;
        end
      end
      S_GINIT: begin
        if (sts.x_zero || sts.y_zero) begin
          dcmd.op    = OP_GCD_FINISH;
          state_next = S_AFTER;
        end else if (sts.both_even) begin
          dcmd.op = OP_SHIFT_BOTH;
        end else begin
          state_next = S_GODD;
        end
      end
      S_GODD: begin
        if (sts.x_even) begin
          dcmd.op = OP_SHIFT_X;
        end else begin
          state_next = S_GLOOP;
        end
      end
      S_GLOOP: begin
        if (sts.y_zero) begin
          dcmd.op    = OP_GCD_FINISH;
          state_next = S_AFTER;
        end else begin
          dcmd.op = OP_GCD_STEP;
        end
      end
      S_AFTER: begin
        if (sts.is_lcm) begin
          dcmd.op    = OP_DIV_START;
          state_next = S_DIV;
        end else begin
          dcmd.op    = OP_MOVE_G;
          state_next = S_NEXT;
        end
      end
      S_DIV: begin
        dcmd.op = OP_DIV_STEP;
        if (sts.div_last) begin
          state_next = S_MULS;
        end
      end
      S_MULS: begin
        dcmd.op    = OP_MUL_START;
        state_next = S_MUL;
      end
      S_MUL: begin
        dcmd.op = OP_MUL_STEP;
        if (sts.mul_last) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        // The third operand gets a second pass against the running value.
        if (sts.three && !sel_c) begin
          sel_c_next = 1'b1;
          dcmd.sel_c = 1'b1;
          dcmd.op    = OP_GCD_START;
          state_next = S_GINIT;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (fin_fire) begin
          dcmd.op    = OP_FINAL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (fin_fire) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel_c     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel_c     <= sel_c_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_loop_x_odd: assert property (@(posedge clk) disable iff (rst)
    (state == S_GLOOP) |-> !sts.x_even)
    else $error("GCD loop entered with even x");

  a_final_sets_valid: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> rsp_valid)
    else $error("result register written without valid");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_CHECK))
    else $error("accepted item did not start");

  a_mul_to_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && sts.mul_last) |=> (state == S_NEXT))
    else $error("multiplier pass did not end");
`endif

endmodule

`default_nettype wire

[rtl/core/gcd_lcm_two_or_three_operands.sv]
// GCD or LCM of two or three unsigned operands, one item at a time. The
// controller runs a binary GCD (one shift or subtract per cycle), then for
// LCM a restoring divide and a shift-add multiply; three operands repeat
// this against the running value. The GCD loop length depends on the
// operand values. A new item is taken only in idle; a finished result
// waits in the output register while the next item runs.
// Depends on gcdlcm_pkg, gcdlcm_in_if, gcdlcm_out_if, gcdlcm_ctrl, gcdlcm_dp.
`default_nettype none

module gcd_lcm_two_or_three_operands (
  input  logic  clk,
  input  logic  rst,
  gcdlcm_in_if.sink    req,
  gcdlcm_out_if.source rsp
);
  import gcdlcm_pkg::*;

  dp_cmd_t dcmd;
  dp_sts_t sts;

  gcdlcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .dcmd      (dcmd)
  );

  gcdlcm_dp u_dp (
    .clk          (clk),
    .cmd_in       (req.cmd),
    .three_in     (req.three_operands),
    .a_in         (req.operand_a),
    .b_in         (req.operand_b),
    .c_in         (req.operand_c),
    .dcmd         (dcmd),
    .sts          (sts),
    .result_value (rsp.result_value),
    .error_flag   (rsp.error_flag)
  );

endmodule

`default_nettype wire
